/* design/simu_pkg.sv */
// Package for the selectable integer math unit: opcodes, status codes,
// controller states and the command/status structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package simu_pkg;

    localparam int OperandWidth = 31;
    localparam int DefaultDataWidth = 32;

    typedef enum logic [1:0] {
        OP_LCM  = 2'd0,
        OP_GCD  = 2'd1,
        OP_FACT = 2'd2,
        OP_REV  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_OVF   = 2'd1,
        ST_UNDEF = 2'd2,
        ST_RSVD  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV_START,
        S_DIV_RUN,
        S_GCD_STEP,
        S_LCM_DIV,
        S_LCM_MUL,
        S_FACT_MUL,
        S_FACT_CHK,
        S_REV_STEP,
        S_REV_UPD,
        S_FINISH
    } state_t;

    // Controller -> datapath commands
    typedef struct packed {
        logic load;        // capture operands
        logic div_start;   // start divider with selected num/den
        logic div_step;    // one restoring division step
        logic [1:0] div_sel; // 0: x%y, 1: a/g
        logic gcd_update;  // x<=y, y<=rem
        logic lcm_quot;    // x<=quot (a/g)
        logic mul_lcm;     // acc<=x*b
        logic fact_mul;    // acc<=acc*i
        logic fact_inc;    // i<=i+1
        logic rev_div;     // quot<=v/10 by reciprocal multiply
        logic rev_update;  // rev<=rev*10+(v-10*quot), v<=quot
        logic finish;      // form result
    } dp_cmd_t;

    // Datapath -> controller status
    typedef struct packed {
        opcode_t op;
        logic    both_zero;
        logic    y_zero;
        logic    v_zero;
        logic    div_done;
        logic    fact_done;  // i > a
        logic    acc_over;   // acc above limit
    } dp_sts_t;

    localparam logic [1:0] DivSelMod  = 2'd0;
    localparam logic [1:0] DivSelLcm  = 2'd1;

endpackage
`default_nettype wire

/* design/selectable_integer_math_unit.sv */
// Top level of the selectable integer math unit (lcm, gcd, factorial,
// decimal reversal). Depends on simu_pkg, simu_ctrl and simu_dp.
`timescale 1ns / 1ps
//
// channel | signals                                          | direction
// --------+--------------------------------------------------+----------
// input   | in_valid, in_stall, opcode, operand_a, operand_b | in
// output  | out_valid, out_stall, result, status             | out
//
// One transaction computed at a time: accept, a decode state, the
// operation, then a write of the output register. Each Euclid step issues
// the divider, runs the bit-serial division and checks for done; lcm adds
// one more division (a/g) and then the multiply. Factorial alternates a
// check and a multiply (at most twelve multiplies before saturation); digit
// reversal takes a reciprocal multiply, then an update, per decimal digit.
// rst_n is asynchronous and clears the controller and the divider count.
// A waiting result sits in the output register while the next transaction
// is accepted and computed; only that one's final write waits on out_stall.
`default_nettype none
module selectable_integer_math_unit #(
    parameter int DATA_WIDTH = simu_pkg::DefaultDataWidth
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic in_stall,
    input  wire logic [1:0] opcode,
    input  wire logic [simu_pkg::OperandWidth-1:0] operand_a,
    input  wire logic [simu_pkg::OperandWidth-1:0] operand_b,
    output logic out_valid,
    input  wire logic out_stall,
    output logic [simu_pkg::OperandWidth-1:0] result,
    output logic [1:0] status
);
    import simu_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    // sequencer: one state per step of the chosen operation
    simu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    // shared divider, multiplier and result register
    simu_dp #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .opcode    (opcode),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .cmd       (cmd),
        .sts       (sts),
        .result    (result),
        .status    (status)
    );
endmodule
`default_nettype wire

/* design/simu_ctrl.sv */
// Controller FSM for the selectable integer math unit.
// Depends on simu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module simu_ctrl (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic in_stall,
    output logic out_valid,
    input  wire logic out_stall,
    output simu_pkg::dp_cmd_t cmd,
    input  wire simu_pkg::dp_sts_t sts
);
    import simu_pkg::*;

    state_t state_reg, state_next;
    // where the divider returns to
    logic [1:0] ret_reg, ret_next;
    // output register holds a result
    logic out_valid_reg, out_valid_next;

    localparam logic [1:0] RetGcd = 2'd0;
    localparam logic [1:0] RetLcm = 2'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= RetGcd;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_valid) state_next = S_DIV_START;
            S_DIV_START:
            begin
                // decode operation after operand load
                unique case (sts.op)
                    OP_LCM:
                        if (sts.both_zero) state_next = S_FINISH;
                        else state_next = S_GCD_STEP;
                    OP_GCD:  state_next = S_GCD_STEP;
                    OP_FACT: state_next = S_FACT_CHK;
                    OP_REV:  state_next = S_REV_STEP;
                endcase
            end
            S_GCD_STEP:
                if (sts.y_zero)
                begin
                    if (sts.op == OP_LCM)
                    begin
                        state_next = S_DIV_RUN;
                        ret_next   = RetLcm;
                    end
                    else state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_DIV_RUN;
                    ret_next   = RetGcd;
                end
            S_REV_STEP:
                if (sts.v_zero) state_next = S_FINISH;
                else state_next = S_REV_UPD;
            S_REV_UPD:  state_next = S_REV_STEP;
            S_DIV_RUN:
                if (sts.div_done)
                begin
                    priority case (ret_reg)
                        RetGcd:  state_next = S_GCD_STEP;
                        default: state_next = S_LCM_DIV;
                    endcase
                end
            S_LCM_DIV:  state_next = S_LCM_MUL;
            S_LCM_MUL:  state_next = S_FINISH;
            S_FACT_CHK:
                if (sts.fact_done || sts.acc_over) state_next = S_FINISH;
                else state_next = S_FACT_MUL;
            S_FACT_MUL: state_next = S_FACT_CHK;
            // wait until the output register is free or being emptied
            S_FINISH:
                if (!out_valid_reg || !out_stall) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        in_stall  = (state_reg != S_IDLE);
        out_valid = out_valid_reg;
        unique case (state_reg)
            S_IDLE:     cmd.load = in_valid;
            S_GCD_STEP:
            begin
                // kick divider: x%y, or a/g when gcd is found
                cmd.div_start = 1'b1;
                cmd.div_sel   = sts.y_zero ? DivSelLcm : DivSelMod;
            end
            S_REV_STEP: cmd.rev_div    = !sts.v_zero;
            S_REV_UPD:  cmd.rev_update = 1'b1;
            S_DIV_RUN:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                    cmd.gcd_update = (ret_reg == RetGcd);
            end
            S_LCM_DIV:  cmd.lcm_quot = 1'b1;
            S_LCM_MUL:  cmd.mul_lcm  = 1'b1;
            S_FACT_MUL:
            begin
                cmd.fact_mul = 1'b1;
                cmd.fact_inc = 1'b1;
            end
            S_FINISH:   cmd.finish = !out_valid_reg || !out_stall;
            default:    cmd = '0;
        endcase
        out_valid_next = out_valid_reg && out_stall;
        if (cmd.finish) out_valid_next = 1'b1;
    end
endmodule
`default_nettype wire

/* design/simu_dp.sv */
// Datapath for the selectable integer math unit: operand registers,
// a shared bit-serial divider, a 31x31 multiplier and the result register.
// Depends on simu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module simu_dp #(
    parameter int DATA_WIDTH = simu_pkg::DefaultDataWidth
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic [1:0] opcode,
    input  wire logic [simu_pkg::OperandWidth-1:0] operand_a,
    input  wire logic [simu_pkg::OperandWidth-1:0] operand_b,
    input  wire simu_pkg::dp_cmd_t cmd,
    output simu_pkg::dp_sts_t sts,
    output logic [simu_pkg::OperandWidth-1:0] result,
    output logic [1:0] status
);
    import simu_pkg::*;

    localparam int W = OperandWidth;
    localparam int LimW = (DATA_WIDTH - 1 > W) ? W : DATA_WIDTH - 1;
    localparam logic [2*W-1:0] Limit = (2*W)'((64'd1 << LimW) - 64'd1);
    localparam int CntW = $clog2(W + 1);
    // ceil(2^35 / 10): (v * TenRecip) >> 35 is v / 10 for any 32-bit v
    localparam logic [31:0] TenRecip = 32'hCCCC_CCCD;

    opcode_t op_reg;
    logic [W-1:0] a_reg, b_reg, x_reg, y_reg, v_reg;
    logic [2*W-1:0] acc_reg, acc_next;  // factorial product / lcm / reversal
    logic [W:0] i_reg;                  // factorial counter
    // divider
    logic [W-1:0] dnum_reg, dden_reg, quot_reg, rem_reg;
    logic [CntW-1:0] dcnt_reg;
    logic [W-1:0] div_num, div_den;
    logic [W:0] rem_shift;
    // decimal digit split
    logic [63:0] ten_prod;
    logic [W-1:0] rev_quot, rev_rem;
    logic [W-1:0] res_reg;
    status_t st_reg;

    always_comb
    begin
        unique case (cmd.div_sel)
            DivSelLcm:
            begin
                div_num = a_reg;
                div_den = x_reg;
            end
            default:
            begin
                div_num = x_reg;
                div_den = y_reg;
            end
        endcase
    end

    assign rem_shift = {rem_reg, dnum_reg[W-1]};

    assign ten_prod = {33'd0, v_reg} * {32'd0, TenRecip};
    assign rev_quot = W'(ten_prod[63:35]);
    assign rev_rem  = v_reg - W'(quot_reg * W'(10));

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            dnum_reg <= div_num;
            dden_reg <= div_den;
            quot_reg <= '0;
            rem_reg  <= '0;
        end
        else if (cmd.div_step && dcnt_reg != '0)
        begin
            dnum_reg <= {dnum_reg[W-2:0], 1'b0};
            if (rem_shift >= {1'b0, dden_reg})
            begin
                rem_reg  <= W'(rem_shift - {1'b0, dden_reg});
                quot_reg <= {quot_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_shift[W-1:0];
                quot_reg <= {quot_reg[W-2:0], 1'b0};
            end
        end
        else if (cmd.rev_div)
            quot_reg <= rev_quot;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) dcnt_reg <= '0;
        else if (cmd.div_start) dcnt_reg <= CntW'(W);
        else if (cmd.div_step && dcnt_reg != '0) dcnt_reg <= dcnt_reg - 1'b1;
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.load) acc_next = (opcode == OP_FACT) ? (2*W)'(1) : '0;
        else if (cmd.fact_mul)
            acc_next = (2*W)'(acc_reg[W-1:0]) * (2*W)'(i_reg[W-1:0]);
        else if (cmd.mul_lcm) acc_next = (2*W)'(x_reg) * (2*W)'(b_reg);
        else if (cmd.rev_update)
            acc_next = (2*W)'(acc_reg * (2*W)'(10)) + (2*W)'(rev_rem);
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (cmd.load)
        begin
            op_reg <= opcode_t'(opcode);
            a_reg  <= operand_a;
            b_reg  <= operand_b;
            x_reg  <= operand_a;
            y_reg  <= operand_b;
            v_reg  <= operand_b;
            i_reg  <= (W+1)'(2);
        end
        else
        begin
            if (cmd.gcd_update)
            begin
                x_reg <= y_reg;
                y_reg <= rem_reg;
            end
            if (cmd.lcm_quot) x_reg <= quot_reg;
            if (cmd.rev_update) v_reg <= quot_reg;
            if (cmd.fact_inc) i_reg <= i_reg + 1'b1;
        end
        if (cmd.finish)
        begin
            unique case (op_reg)
                OP_LCM:
                    if (a_reg == '0 && b_reg == '0)
                    begin
                        res_reg <= '0;
                        st_reg  <= ST_UNDEF;
                    end
                    else if (acc_reg > Limit)
                    begin
                        res_reg <= Limit[W-1:0];
                        st_reg  <= ST_OVF;
                    end
                    else
                    begin
                        res_reg <= acc_reg[W-1:0];
                        st_reg  <= ST_OK;
                    end
                OP_GCD:
                    if ({{W{1'b0}}, x_reg} > Limit)
                    begin
                        res_reg <= Limit[W-1:0];
                        st_reg  <= ST_OVF;
                    end
                    else
                    begin
                        res_reg <= x_reg;
                        st_reg  <= ST_OK;
                    end
                default:
                    if (acc_reg > Limit)
                    begin
                        res_reg <= Limit[W-1:0];
                        st_reg  <= ST_OVF;
                    end
                    else
                    begin
                        res_reg <= acc_reg[W-1:0];
                        st_reg  <= ST_OK;
                    end
            endcase
        end
    end

    always_comb
    begin
        sts.op        = op_reg;
        sts.both_zero = (a_reg == '0) && (b_reg == '0);
        sts.y_zero    = (y_reg == '0);
        sts.v_zero    = (v_reg == '0);
        sts.div_done  = (dcnt_reg == '0);
        sts.fact_done = (i_reg > {1'b0, a_reg});
        sts.acc_over  = (acc_reg > Limit);
    end

    assign result = res_reg;
    assign status = st_reg;
endmodule
`default_nettype wire

/* tb/selectable_integer_math_unit_tb.sv */
// Testbench for selectable_integer_math_unit: directed and random transactions
// checked against an in-bench predictor. Depends on simu_pkg and the RTL top.
`timescale 1ns / 1ps
`default_nettype none
module selectable_integer_math_unit_tb;
    import simu_pkg::*;

    localparam int W = OperandWidth;
    localparam logic [63:0] LIMIT_VAL = 64'h7FFF_FFFF;   // 2^(32-1)-1
    localparam longint MAX_CYCLES = 6_000_000;
    localparam int N_RANDOM = 730;

    // one pending input transaction; drain asks the sender to wait for an empty pipe
    typedef struct {
        opcode_t      op;
        logic [W-1:0] a;
        logic [W-1:0] b;
        bit           drain;
    } math_req_t;

    typedef struct {
        logic [W-1:0] value;
        status_t      st;
    } math_ans_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] opcode = '0;
    logic [W-1:0] operand_a = '0;
    logic [W-1:0] operand_b = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [W-1:0] result;
    logic [1:0] status;

    math_req_t req_q[$];
    math_ans_t ans_q[$];
    int  n_sent = 0;        // transactions put on the input port
    int  n_taken = 0;       // transactions accepted at a rising edge
    int  n_fail = 0;
    bit  stim_done = 1'b0;
    longint cyc = 0;

    selectable_integer_math_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .operand_a(operand_a), .operand_b(operand_b),
        .out_valid(out_valid), .out_stall(out_stall),
        .result(result), .status(status)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Predictor: Euclid, factorial with early saturation, digit reversal
    // ---------------------------------------------------------------
    function automatic logic [63:0] euclid(logic [63:0] x, logic [63:0] y);
        logic [63:0] t;
        while (y != 0)
        begin
            t = y;
            y = x % y;
            x = t;
        end
        return x;
    endfunction

    function automatic math_ans_t saturate(logic [63:0] v, bit ovf);
        math_ans_t r;
        if (ovf || v > LIMIT_VAL)
        begin
            r.value = LIMIT_VAL[W-1:0];
            r.st = ST_OVF;
        end
        else
        begin
            r.value = v[W-1:0];
            r.st = ST_OK;
        end
        return r;
    endfunction

    function automatic math_ans_t predict_math(opcode_t op, logic [W-1:0] a_in,
                                               logic [W-1:0] b_in);
        logic [63:0] a, b, g, x, v, rev;
        bit ovf;
        math_ans_t r;
        a = 64'(a_in);
        b = 64'(b_in);
        case (op)
            OP_LCM:
            begin
                if (a == 0 && b == 0)
                begin
                    r.value = '0;
                    r.st = ST_UNDEF;
                end
                else
                begin
                    g = euclid(a, b);
                    r = saturate((a / g) * b, 1'b0);
                end
            end
            OP_GCD: r = saturate(euclid(a, b), 1'b0);
            OP_FACT:
            begin
                x = 1;
                ovf = 1'b0;
                for (longint i = 2; i <= a && !ovf; i++)
                begin
                    x = x * i;
                    if (x > LIMIT_VAL)
                        ovf = 1'b1;
                end
                r = saturate(x, ovf);
            end
            default:
            begin
                rev = 0;
                v = b;
                while (v != 0)
                begin
                    rev = rev * 10 + (v % 10);
                    v = v / 10;
                end
                r = saturate(rev, 1'b0);
            end
        endcase
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus construction
    // ---------------------------------------------------------------
    function automatic logic [W-1:0] pick_operand();
        case ($urandom_range(0, 4))
            0: return W'($urandom_range(0, 20));
            1: return W'($urandom_range(0, 100000));
            2: return W'($urandom_range(1, 9999)) * W'(10 ** $urandom_range(0, 5));
            default: return W'($urandom);
        endcase
    endfunction

    task automatic add_req(opcode_t op, longint a, longint b, int drain);
        math_req_t r;
        r.op = op;
        r.a = W'(a);
        r.b = W'(b);
        r.drain = (drain != 0);
        req_q.push_back(r);
    endtask

    initial
    begin
        logic [W-1:0] a, b;
        opcode_t op;
        // directed: corner operands of each operation
        add_req(OP_LCM, 0, 0, 0);                       // undefined
        add_req(OP_LCM, 0, 5, 0);
        add_req(OP_LCM, 6, 0, 0);
        add_req(OP_LCM, 4, 6, 0);
        add_req(OP_LCM, '1, '1, 0);
        add_req(OP_LCM, '1, '1 - 1, 0);                 // saturates
        add_req(OP_LCM, 46340, 46341, 0);
        add_req(OP_GCD, 0, 0, 0);
        add_req(OP_GCD, 7, 0, 0);                       // b zero returns a
        add_req(OP_GCD, 0, 9, 0);
        add_req(OP_GCD, '1, '1, 0);
        add_req(OP_GCD, 1836311903, 1134903170, 0);     // longest Euclid chain
        add_req(OP_GCD, 1134903170, 1836311903, 0);
        add_req(OP_FACT, 0, '1, 0);
        add_req(OP_FACT, 1, 0, 0);
        add_req(OP_FACT, 12, 0, 0);
        add_req(OP_FACT, 13, 0, 0);                     // first to saturate
        add_req(OP_FACT, '1, '1, 0);
        add_req(OP_REV, '1, 0, 0);
        add_req(OP_REV, 0, 120, 0);                     // trailing zeros vanish
        add_req(OP_REV, 0, '1, 0);                      // reversal too large
        add_req(OP_REV, 0, 1463847412, 0);
        add_req(OP_REV, '1, 1000000000, 1);
        for (int i = 0; i < N_RANDOM; i++)
        begin
            op = opcode_t'($urandom_range(0, 3));
            a = pick_operand();
            b = pick_operand();
            if (op == OP_FACT && $urandom_range(0, 2) != 0)
                a = W'($urandom_range(0, 15));
            add_req(op, longint'(a), longint'(b), ((i % 250) == 249) ? 1 : 0);
        end
    end

    // ---------------------------------------------------------------
    // Driver: bursts and gaps, updated at the falling edge
    // ---------------------------------------------------------------
    int burst_left = 0;
    int gap_left = 0;

    always @(negedge clk)
    begin
        math_req_t nx;
        if (rst_n && (!in_valid || n_taken == n_sent))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (req_q.size() == 0)
            begin
                in_valid <= 1'b0;
                stim_done <= 1'b1;
            end
            else if (req_q[0].drain && ans_q.size() != 0)
                in_valid <= 1'b0;                      // wait for an empty pipe
            else
            begin
                nx = req_q.pop_front();
                in_valid <= 1'b1;
                opcode <= nx.op;
                operand_a <= nx.a;
                operand_b <= nx.b;
                n_sent <= n_sent + 1;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(0, 12);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 40);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Receiver stall pattern, with one long hold-off
    // ---------------------------------------------------------------
    int stall_mode = 0;
    int mode_left = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    always @(negedge clk)
    begin
        if (!hold_done && n_taken >= 60)
        begin
            hold_done <= 1'b1;
            hold_left <= 4000;                         // long enough to back up the input
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 2);
                mode_left = $urandom_range(50, 3000);
            end
            else
                mode_left--;
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                default: out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Monitor: record accepted inputs, check accepted results
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        math_ans_t e;
        cyc <= cyc + 1;
        if (rst_n && in_valid && !in_stall)
        begin
            ans_q.push_back(predict_math(opcode_t'(opcode), operand_a, operand_b));
            n_taken <= n_taken + 1;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (ans_q.size() == 0)
            begin
                n_fail++;
                if (n_fail <= 10)
                    $display("unexpected result %0d status %0d", result, status);
            end
            else
            begin
                e = ans_q.pop_front();
                if (result !== e.value || status !== 2'(e.st))
                begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("mismatch: result %0d/%0d status %0d/%0d (exp/got)",
                                 e.value, result, e.st, status);
                end
            end
        end
        if (cyc > MAX_CYCLES)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Reset, end of run
    // ---------------------------------------------------------------
    initial
    begin
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        wait (stim_done && !in_valid && ans_q.size() == 0);
        repeat (3000) @(posedge clk);                  // catch any extra result
        if (n_fail == 0 && ans_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
`default_nettype wire
